/* rtl/core/bounded_array_list_engine_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded array list engine
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define BAL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bal assertion failed");

// next-cycle implication, disabled while reset is high
`define BAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bal assertion failed");

`endif

/* rtl/core/bal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg
// Types, sizes and mode codes of the bounded array list engine.
// ----------------------------------------------------------------------------
package bal_pkg;

   localparam int CAPACITY   = 64;
   localparam int WORD_W     = 32;
   localparam int MODE_W     = 3;
   localparam int POS_W      = 7;
   localparam int FILL_W     = 7;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int EXT_W      = (POS_W > IDX_W) ? POS_W : IDX_W;
   localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   // stream payload layout
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SWAP       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd5;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd6;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [IDX_W-1:0]         idx_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              write_en;
      logic [MODE_W-1:0] mode;
      idx_type           idx_a;
      idx_type           idx_b;
      idx_type           tail;
      word_type          value;
      word_type          a_val;
      word_type          b_val;
   } cell_ctrl_type;

   // 1-based position to cell index
   function automatic idx_type idx_of(input logic [POS_W-1:0] pos);
      logic [EXT_W-1:0] tmp;
      tmp = EXT_W'(pos) - EXT_W'(1);
      return tmp[IDX_W-1:0];
   endfunction

endpackage

/* rtl/core/bal_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_cell
// One list slot: holds a word and loads from a neighbor, the request or zero.
// ----------------------------------------------------------------------------
module bal_cell import bal_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  idx_type       cell_idx,
   input  cell_ctrl_type ctrl,
   input  word_type      left_in,
   input  word_type      right_in,
   output word_type      entry_out
);

   word_type entry_ff;
   word_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write_en) begin
         unique case (ctrl.mode)
            MODE_PUSH_FRONT: begin
               entry_in = (cell_idx == '0) ? ctrl.value : left_in;
            end
            MODE_PUSH_BACK: begin
               if (cell_idx == ctrl.tail) entry_in = ctrl.value;
            end
            MODE_INSERT: begin
               if (cell_idx == ctrl.idx_a) entry_in = ctrl.value;
               else if (cell_idx > ctrl.idx_a) entry_in = left_in;
            end
            MODE_ERASE: begin
               if (cell_idx >= ctrl.idx_a) entry_in = right_in;
            end
            MODE_SWAP: begin
               if (cell_idx == ctrl.idx_a) entry_in = ctrl.b_val;
               else if (cell_idx == ctrl.idx_b) entry_in = ctrl.a_val;
            end
            MODE_CLEAR: begin
               entry_in = '0;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= '0;
      else       entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

/* rtl/core/bal_gather.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_gather
// Two-level read tree: registered group picks, then a narrow OR of groups.
// ----------------------------------------------------------------------------
module bal_gather import bal_pkg::*; (
   input  logic     clock,
   input  word_type entries [CAPACITY],
   input  idx_type  idx_a,
   input  idx_type  idx_b,
   output word_type rd_a,
   output word_type rd_b
);

   word_type group_a_ff [NUM_GROUPS];
   word_type group_b_ff [NUM_GROUPS];
   word_type group_a_in [NUM_GROUPS];
   word_type group_b_in [NUM_GROUPS];

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      always_comb begin
         group_a_in[g] = '0;
         group_b_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               if (idx_a == IDX_W'(g * GROUP_SIZE + k))
                  group_a_in[g] = group_a_in[g] | entries[g * GROUP_SIZE + k];
               if (idx_b == IDX_W'(g * GROUP_SIZE + k))
                  group_b_in[g] = group_b_in[g] | entries[g * GROUP_SIZE + k];
            end
         end
      end

      always_ff @(posedge clock) begin
         group_a_ff[g] <= group_a_in[g];
         group_b_ff[g] <= group_b_in[g];
      end
   end

   always_comb begin
      rd_a = '0;
      rd_b = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rd_a = rd_a | group_a_ff[g];
         rd_b = rd_b | group_b_ff[g];
      end
   end

endmodule

/* rtl/core/bounded_array_list_engine.sv */
// One request at a time passes the accept, gather and execute states, and its
// result is then registered. The gather state lets the registered two-level read
// tree feed read-at and swap; execute waits while an unaccepted result holds the output.
// Shift modes move the affected cells by one place in the execute cycle, all at once.
// Reset (synchronous, high) zeroes all entries and the count and empties the output.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Fixed-capacity ordered list of signed words built as a chain of cells.
// ----------------------------------------------------------------------------
module bounded_array_list_engine import bal_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] mode, [9:3] position, [16:10] position_b, [48:17] value, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] status, [32:1] read_value, [39:33] fill_count, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_GATHER = 2'd1;
   localparam logic [1:0] S_EXEC   = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;

   // request held for the duration of its work
   logic [MODE_W-1:0] mode_ff;
   logic [POS_W-1:0]  pa_ff;
   logic [POS_W-1:0]  pb_ff;
   word_type          val_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic          req_take;
   logic          exec_go;
   logic          ok;
   logic          full;
   logic          pa_in_list;
   logic          pb_in_list;
   logic [CMP_W-1:0] pa_w;
   logic [CMP_W-1:0] pb_w;
   logic [CMP_W-1:0] cnt_w;
   word_type      rd_a;
   word_type      rd_b;
   word_type      rd_out;
   idx_type       idx_a;
   idx_type       idx_b;
   cell_ctrl_type ctrl;
   word_type      entries [CAPACITY];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   // execute only once the output register can take the result
   assign exec_go    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_take) state_in = S_GATHER;
         S_GATHER: state_in = S_EXEC;
         S_EXEC:   if (exec_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_tdata[2:0];
         pa_ff   <= req_tdata[9:3];
         pb_ff   <= req_tdata[16:10];
         val_ff  <= req_tdata[48:17];
      end
   end

   assign idx_a = idx_of(pa_ff);
   assign idx_b = idx_of(pb_ff);

   // registers the words at both positions in the gather state, ahead of execute
   bal_gather u_gather (
      .clock   (clock),
      .entries (entries),
      .idx_a   (idx_a),
      .idx_b   (idx_b),
      .rd_a    (rd_a),
      .rd_b    (rd_b)
   );

   // bounds checks
   assign pa_w       = CMP_W'(pa_ff);
   assign pb_w       = CMP_W'(pb_ff);
   assign cnt_w      = CMP_W'(count_ff);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign pa_in_list = (pa_w != '0) && (pa_w <= cnt_w);
   assign pb_in_list = (pb_w != '0) && (pb_w <= cnt_w);

   always_comb begin
      ok       = 1'b1;
      count_in = count_ff;
      unique case (mode_ff) inside
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            ok = !full;
            if (ok) count_in = count_ff + CNT_W'(1);
         end
         MODE_INSERT: begin
            ok = !full && (pa_w != '0) && (pa_w <= cnt_w + CMP_W'(1));
            if (ok) count_in = count_ff + CNT_W'(1);
         end
         MODE_ERASE: begin
            ok = pa_in_list;
            if (ok) count_in = count_ff - CNT_W'(1);
         end
         MODE_SWAP:  ok = pa_in_list && pb_in_list;
         MODE_READ:  ok = pa_in_list;
         MODE_CLEAR: count_in = '0;
         default:    ok = 1'b1;
      endcase
   end

   assign rd_out = (mode_ff == MODE_READ && ok) ? rd_a : '0;

   // cell control broadcast; reads and the unused mode write nothing
   always_comb begin
      ctrl.write_en = exec_go && ok && (mode_ff != MODE_READ);
      ctrl.mode     = mode_ff;
      ctrl.idx_a    = idx_a;
      ctrl.idx_b    = idx_b;
      ctrl.tail     = count_ff[IDX_W-1:0];
      ctrl.value    = val_ff;
      ctrl.a_val    = rd_a;
      ctrl.b_val    = rd_b;
   end

   // the chain: each cell sees the words of its two neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_w;
      word_type right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = entries[i+1];
      end

      bal_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(i)),
         .ctrl      (ctrl),
         .left_in   (left_w),
         .right_in  (right_w),
         .entry_out (entries[i])
      );
   end

   // output register; the three fields fill tdata exactly
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {count_in[FILL_W-1:0], rd_out, !ok};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (exec_go) count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/core/bal_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_checker
// Port-level checks of the bounded array list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_macros.svh"

module bal_checker import bal_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // no result straight out of reset
   `BAL_ASSERT_IMPLY(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid)

   // a failed request never carries a read word
   `BAL_ASSERT_IMPLY(a_fail_reads_zero, clock, reset,
      rsp_tvalid && rsp_tdata[0], rsp_tdata[32:1] == '0)

   // count never exceeds the capacity
   `BAL_ASSERT_IMPLY(a_count_bound, clock, reset,
      rsp_tvalid, 32'(rsp_tdata[39:33]) <= 32'(CAPACITY))

   // a stalled result holds
   `BAL_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one request in flight: input closes right after a transfer
   `BAL_ASSERT_NEXT(a_req_one_at_a_time, clock, reset,
      req_tvalid && req_tready, !req_tready)

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (.*);
